// ===== design/pvt_pkg.sv =====
// ----------------------------------------------------------------------------
// pvt_pkg
// Shared types and constants of the pointer velocity tracker.
// ----------------------------------------------------------------------------
package pvt_pkg;

  localparam int SUM_W = 28;

  localparam logic [7:0] DIR_N = 8'h01;
  localparam logic [7:0] DIR_E = 8'h04;
  localparam logic [7:0] DIR_S = 8'h10;
  localparam logic [7:0] DIR_W = 8'h40;

  // tan(22.5 deg) as 414/1000
  localparam logic [9:0] THR_NUM = 10'd414;
  localparam logic [9:0] THR_DEN = 10'd1000;

  typedef enum logic [2:0] {
    REG_CORR  = 3'd0,
    REG_CONST = 3'd1,
    REG_ABS   = 3'd2,
    REG_REL   = 3'd3,
    REG_FIRST = 3'd4,
    REG_EXP   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] correction_gain;
    logic [15:0] constant_gain;
    logic [31:0] max_abs_jump;
    logic [15:0] max_rel_jump;
    logic [3:0]  first_usable_offset;
    logic [15:0] expire_ms;
  } cfg_t;

  // request to the shared divide unit
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [39:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;

endpackage

// ===== design/pvt_if.sv =====
// ----------------------------------------------------------------------------
// pvt_if
// Valid/ready channels of the pointer velocity tracker.
// ----------------------------------------------------------------------------
interface pvt_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] delta_x;
  logic signed [23:0] delta_y;
  logic [31:0]        stamp_ms;
  modport source (output valid, delta_x, delta_y, stamp_ms, input ready);
  modport sink (input valid, delta_x, delta_y, stamp_ms, output ready);
endinterface

interface pvt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] velocity;
  logic [7:0]  direction;
  modport source (output valid, velocity, direction, input ready);
  modport sink (input valid, velocity, direction, output ready);
endinterface

interface pvt_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/pvt_div.sv =====
// ----------------------------------------------------------------------------
// pvt_div
// Shared restoring divider, one quotient bit a cycle, 64-bit numerator.
// ----------------------------------------------------------------------------
module pvt_div (
  input  logic             clk,
  input  logic             rst,
  input  pvt_pkg::div_req_t req,
  output pvt_pkg::div_rsp_t rsp
);
  import pvt_pkg::*;

  logic [63:0] quot;
  logic [40:0] rem;
  logic [39:0] den;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [40:0] trial;

  assign trial = {rem[39:0], quot[63]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // pulse with the last quotient bit
      done <= !req.start && busy && (cnt == 7'd1);
      if (req.start) begin
        busy <= 1'b1;
        quot <= req.num;
        den  <= req.den;
        rem  <= '0;
        cnt  <= 7'd64;
      end else if (busy) begin
        if (!trial[40]) begin
          rem  <= trial;
          quot <= {quot[62:0], 1'b1};
        end else begin
          rem  <= {rem[39:0], quot[63]};
          quot <= {quot[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp = {done, quot};
endmodule

// ===== design/pointer_velocity_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// pointer_velocity_tracker_unit
// Pointer velocity estimation over a ring of motion trackers.
// ----------------------------------------------------------------------------
// One request in, one result out. After acceptance the block updates all
// trackers, one per cycle, restarts the next tracker, then walks
// back over up to TRACKERS-1 older trackers. Each step runs a bit-serial
// square root (28 steps), two gain multiplies and a 64-step divide
// in the shared divider. Input is not ready until the result has been taken.
// Tracker storage is cleared by reset in flip-flops.
module pointer_velocity_tracker_unit #(
  parameter int TRACKERS = 16
) (
  input logic     clk,
  input logic     rst,
  pvt_in_if.sink  in_ch,
  pvt_out_if.source out_ch,
  pvt_cfg_if.sink cfg_ch
);
  import pvt_pkg::*;

  localparam int IW = (TRACKERS > 1) ? $clog2(TRACKERS) : 1;
  localparam logic signed [SUM_W:0] SMAX = (1 <<< (SUM_W - 1)) - 1;
  localparam logic signed [SUM_W:0] SMIN = -(1 <<< (SUM_W - 1));

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_UPD  = 10'b0000000010,
    S_WALK = 10'b0000000100,
    S_SQRT = 10'b0000001000,
    S_MUL1 = 10'b0000010000,
    S_MUL2 = 10'b0000100000,
    S_DIV  = 10'b0001000000,
    S_JUMP = 10'b0010000000,
    S_OUT  = 10'b0100000000,
    S_SQ   = 10'b1000000000
  } state_t;

  state_t state;
  cfg_t   cfg;

  logic signed [SUM_W-1:0] sum_x [TRACKERS];
  logic signed [SUM_W-1:0] sum_y [TRACKERS];
  logic [31:0] start_ms  [TRACKERS];
  logic [7:0]  start_dir [TRACKERS];
  logic [IW-1:0] newest;

  logic signed [23:0] dx, dy;
  logic [31:0] now;
  logic [7:0]  dir;
  logic [IW:0] cnt;
  logic [IW:0] off;
  logic [IW-1:0] idx;
  logic [31:0] age;
  logic [31:0] vel;
  logic        found;
  logic [31:0] tv;

  // square root working registers
  logic [55:0] sq_v;
  logic [55:0] sq_r;
  logic [55:0] sq_b;
  logic [63:0] prod;

  div_req_t dreq;
  div_rsp_t drsp;

  pvt_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // direction classification
  function automatic logic [7:0] classify(input logic signed [23:0] x,
                                          input logic signed [23:0] y);
    logic [7:0]  d;
    logic [23:0] ax, ay;
    logic [33:0] lx, ly, rx, ry;
    d  = '0;
    ax = x[23] ? 24'(-x) : 24'(x);
    ay = y[23] ? 24'(-y) : 24'(y);
    lx = 34'(ax) * 34'(THR_DEN);
    ly = 34'(ay) * 34'(THR_DEN);
    rx = 34'(ax) * 34'(THR_NUM);
    ry = 34'(ay) * 34'(THR_NUM);
    if (y != 0) begin
      if (!x[23] && x != 0 && lx > ry) d = d | DIR_E;
      if (x[23] && lx > ry) d = d | DIR_W;
      d = d | (y[23] ? DIR_N : DIR_S);
    end
    if (x != 0) begin
      if (!y[23] && y != 0 && ly > rx) d = d | DIR_S;
      if (y[23] && ly > rx) d = d | DIR_N;
      d = d | (x[23] ? DIR_W : DIR_E);
    end
    return d;
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0] s, input logic signed [23:0] d);
    logic signed [SUM_W:0] t;
    t = SUM_W'(0) + (SUM_W + 1)'(s) + (SUM_W + 1)'(d);
    if (t > SMAX) t = SMAX;
    if (t < SMIN) t = SMIN;
    return t[SUM_W-1:0];
  endfunction

  logic [IW-1:0] cidx;
  logic [SUM_W-1:0] axs, ays;
  logic [31:0] diff, mx;
  logic [47:0] relp;
  logic [55:0] sq_t;
  logic        jump_bad;

  assign cidx = cnt[IW-1:0];
  assign axs = sum_x[idx][SUM_W-1] ? SUM_W'(-sum_x[idx]) : SUM_W'(sum_x[idx]);
  assign ays = sum_y[idx][SUM_W-1] ? SUM_W'(-sum_y[idx]) : SUM_W'(sum_y[idx]);
  assign diff = (tv > vel) ? tv - vel : vel - tv;
  assign mx   = (tv > vel) ? tv : vel;
  assign relp = 48'(cfg.max_rel_jump) * 48'(mx);
  assign jump_bad = (diff > cfg.max_abs_jump) && ({diff, 16'h0} > relp);
  assign sq_t = sq_r + sq_b;

  assign in_ch.ready  = (state == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.velocity  = vel;
  assign out_ch.direction = dir;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.correction_gain     <= 16'd2560;
      cfg.constant_gain       <= 16'd256;
      cfg.max_abs_jump        <= 32'd65536;
      cfg.max_rel_jump        <= 16'd13107;
      cfg.first_usable_offset <= 4'd2;
      cfg.expire_ms           <= 16'd300;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_CORR:  cfg.correction_gain     <= cfg_ch.data[15:0];
        REG_CONST: cfg.constant_gain       <= cfg_ch.data[15:0];
        REG_ABS:   cfg.max_abs_jump        <= cfg_ch.data;
        REG_REL:   cfg.max_rel_jump        <= cfg_ch.data[15:0];
        REG_FIRST: cfg.first_usable_offset <= cfg_ch.data[3:0];
        REG_EXP:   cfg.expire_ms           <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      newest <= '0;
      dreq.start <= 1'b0;
      for (int i = 0; i < TRACKERS; i++) begin
        sum_x[i] <= '0;
        sum_y[i] <= '0;
        start_ms[i]  <= '0;
        start_dir[i] <= '0;
      end
    end else begin
      // divider start pulse leaving the second multiply
      dreq.start <= (state == S_MUL2);
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            dx    <= in_ch.delta_x;
            dy    <= in_ch.delta_y;
            now   <= in_ch.stamp_ms;
            dir   <= classify(in_ch.delta_x, in_ch.delta_y);
            cnt   <= '0;
            state <= S_UPD;
          end
        end
        // one tracker accumulated per cycle, then restart the next one
        S_UPD: begin
          if (cnt == (IW + 1)'(TRACKERS)) begin
            logic [IW-1:0] nn;
            nn = (newest == IW'(TRACKERS - 1)) ? '0 : newest + IW'(1);
            newest <= nn;
            sum_x[nn] <= '0;
            sum_y[nn] <= '0;
            start_ms[nn]  <= now;
            start_dir[nn] <= dir;
            off   <= (IW + 1)'(1);
            idx   <= (nn == '0) ? IW'(TRACKERS - 1) : nn - IW'(1);
            vel   <= '0;
            found <= 1'b0;
            state <= S_WALK;
          end else begin
            sum_x[cidx] <= sat_add(sum_x[cidx], dx);
            sum_y[cidx] <= sat_add(sum_y[cidx], dy);
            cnt <= cnt + (IW + 1)'(1);
          end
        end
        S_WALK: begin
          logic [31:0] a;
          a = now - start_ms[idx];
          age <= a;
          if (off == (IW + 1)'(TRACKERS) || a == 0 || a > 32'(cfg.expire_ms) ||
              (off > (IW + 1)'(1) && (start_dir[newest] & start_dir[idx]) == 0)) begin
            state <= S_OUT;
          end else begin
            sq_v  <= 56'(axs) * 56'(axs);
            prod  <= 64'(ays) * 64'(ays);
            state <= S_SQ;
          end
        end
        S_SQ: begin
          sq_v  <= sq_v + prod[55:0];
          sq_r  <= '0;
          sq_b  <= 56'(1) << 54;
          state <= S_SQRT;
        end
        // bit-serial integer root, one result bit a cycle
        S_SQRT: begin
          if (sq_b == 0) begin
            state <= S_MUL1;
          end else begin
            if (sq_v >= sq_t) begin
              sq_v <= sq_v - sq_t;
              sq_r <= (sq_r >> 1) + sq_b;
            end else begin
              sq_r <= sq_r >> 1;
            end
            sq_b <= sq_b >> 2;
          end
        end
        S_MUL1: begin
          prod  <= 64'(sq_r[27:0]) * 64'(cfg.correction_gain);
          state <= S_MUL2;
        end
        S_MUL2: begin
          dreq.num   <= 64'(prod[43:0]) * 64'(cfg.constant_gain);
          dreq.den   <= {age, 8'h0};
          state      <= S_DIV;
        end
        S_DIV: begin
          if (drsp.done) begin
            tv    <= (drsp.quot[63:32] != 0) ? 32'hFFFF_FFFF : drsp.quot[31:0];
            state <= S_JUMP;
          end
        end
        S_JUMP: begin
          state <= S_WALK;
          if (!found) begin
            if (off >= (IW + 1)'(cfg.first_usable_offset)) begin
              vel   <= tv;
              found <= 1'b1;
            end
          end else if (jump_bad) begin
            state <= S_OUT;
          end else begin
            vel <= tv;
          end
          off <= off + (IW + 1)'(1);
          idx <= (idx == '0) ? IW'(TRACKERS - 1) : idx - IW'(1);
        end
        S_OUT: begin
          if (out_ch.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
